// File: rtl/pfc_pkg.sv
// Shared types and constants for the partitioned FFT convolver.
package pfc_pkg;

  localparam int TAP_DEPTH = 4096;
  localparam int TAP_AW    = 12;
  localparam int HIST_AW   = 13;
  localparam int LEN_W     = 13;
  localparam int ACC_W     = 48;
  // epoch sample count saturates once every tap always sees real history
  localparam logic [LEN_W-1:0] VALID_SAT = LEN_W'(TAP_DEPTH + 64);

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TAP    = 2'd1,
    ACT_XFORM  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam logic REG_FILTER_LENGTH = 1'b0;
  localparam logic REG_ADD_MODE      = 1'b1;

  // one frame of work for the MAC engine
  typedef struct packed {
    logic [HIST_AW-1:0] start;  // history address of the frame's first sample
    logic [LEN_W-1:0]   vend;   // epoch samples up to the frame's last sample
    logic [LEN_W-1:0]   len;    // taps in use
  } job_t;

  // memory writes from the front end into the engine's stores
  typedef struct packed {
    logic               hist_we;
    logic [HIST_AW-1:0] hist_addr;
    logic [31:0]        hist_data;  // {addend, sample}
    logic               coef_we;
    logic [TAP_AW-1:0]  coef_addr;
    logic [15:0]        coef_data;
  } mem_wr_t;

endpackage

// File: rtl/pfc_job_fifo.sv
// Two-entry queue of frame jobs between the front end and the MAC engine.
module pfc_job_fifo
  import pfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slot_q[rp_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= job_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/pfc_front.sv
// Front end: accepts requests, holds the tap store, fills history, issues frame jobs.
module pfc_front
  import pfc_pkg::*;
#(
  parameter int FRAME_LEN      = 64,
  parameter int MAX_PARTITIONS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       action_i,
  input  logic [15:0]      sample_in_i,
  input  logic [15:0]      addend_i,
  input  logic [11:0]      tap_index_i,
  input  logic [15:0]      tap_value_i,
  input  logic [LEN_W-1:0] filter_length_i,
  input  logic             job_full_i,
  input  logic             job_empty_i,
  input  logic             back_idle_i,
  output logic             job_push_o,
  output job_t             job_o,
  output mem_wr_t          wr_o
);

  localparam int FW  = $clog2(FRAME_LEN);
  localparam int CAP = (MAX_PARTITIONS * FRAME_LEN > TAP_DEPTH) ? TAP_DEPTH
                                                                 : MAX_PARTITIONS * FRAME_LEN;

  typedef enum logic [1:0] {F_CLEAR, F_RUN, F_WAIT, F_COPY} fstate_e;

  fstate_e            st_q;
  logic [TAP_AW-1:0]  cnt_q;
  logic [FW-1:0]      fill_q;
  logic [HIST_AW-1:0] wp_q;
  logic [LEN_W-1:0]   valid_q, vinc;
  logic [LEN_W-1:0]   len_q, lclamp;
  logic               cp_v_q;
  logic [TAP_AW-1:0]  cp_addr_q;
  logic [15:0]        tap_rd_q;
  logic [15:0]        tap_mem [TAP_DEPTH];
  logic               acc, is_sample, frame_end;
  logic               tap_we;
  logic [TAP_AW-1:0]  tap_wa;
  logic [15:0]        tap_wd;

  assign full      = (st_q != F_RUN) || job_full_i;
  assign acc       = push && !full;
  assign is_sample = acc && (action_i == ACT_SAMPLE);
  assign frame_end = is_sample && (fill_q == FW'(FRAME_LEN - 1));
  assign vinc      = (valid_q == VALID_SAT) ? valid_q : valid_q + LEN_W'(1);

  // map a zero tap count to one and clamp it to what the partitions can hold
  always_comb begin
    lclamp = (filter_length_i == '0) ? LEN_W'(1) : filter_length_i;
    if (lclamp > LEN_W'(CAP)) lclamp = LEN_W'(CAP);
  end

  // tap store write: clearing pass or tap request
  always_comb begin
    tap_we = 1'b0;
    tap_wa = tap_index_i;
    tap_wd = tap_value_i;
    if (st_q == F_CLEAR) begin
      tap_we = 1'b1;
      tap_wa = cnt_q;
      tap_wd = '0;
    end else if (acc && action_i == ACT_TAP) begin
      tap_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) tap_mem[tap_wa] <= tap_wd;
    tap_rd_q <= tap_mem[cnt_q];
  end

  // job and memory writes toward the engine
  assign job_push_o = frame_end;
  assign job_o.start = wp_q - HIST_AW'(FRAME_LEN - 1);
  assign job_o.vend  = vinc;
  assign job_o.len   = len_q;

  assign wr_o.hist_we   = is_sample;
  assign wr_o.hist_addr = wp_q;
  assign wr_o.hist_data = {addend_i, sample_in_i};
  assign wr_o.coef_we   = cp_v_q;
  assign wr_o.coef_addr = cp_addr_q;
  assign wr_o.coef_data = tap_rd_q;

  // sequencer: clear after reset, run, wait for engine, copy taps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= F_CLEAR;
      cnt_q     <= '0;
      fill_q    <= '0;
      wp_q      <= '0;
      valid_q   <= '0;
      len_q     <= LEN_W'(1);
      cp_v_q    <= 1'b0;
      cp_addr_q <= '0;
    end else begin
      cp_v_q    <= (st_q == F_COPY);
      cp_addr_q <= cnt_q;
      unique case (st_q)
        F_CLEAR: begin
          cnt_q <= cnt_q + TAP_AW'(1);
          if (cnt_q == TAP_AW'(TAP_DEPTH - 1)) st_q <= F_RUN;
        end
        F_RUN: begin
          if (is_sample) begin
            wp_q    <= wp_q + HIST_AW'(1);
            valid_q <= vinc;
            fill_q  <= frame_end ? '0 : fill_q + FW'(1);
          end else if (acc && action_i == ACT_XFORM) begin
            valid_q <= LEN_W'(fill_q);
            len_q   <= lclamp;
            st_q    <= F_WAIT;
          end
        end
        F_WAIT: begin
          if (back_idle_i && job_empty_i) begin
            st_q  <= F_COPY;
            cnt_q <= '0;
          end
        end
        F_COPY: begin
          cnt_q <= cnt_q + TAP_AW'(1);
          if (cnt_q == TAP_AW'(len_q - LEN_W'(1))) begin
            st_q  <= F_RUN;
            cnt_q <= '0;
          end
        end
        default: st_q <= F_RUN;
      endcase
    end
  end

endmodule

// File: rtl/pfc_back.sv
// MAC engine: per output sample, sums taps times history, rounds to Q1.15, optionally adds the addend and saturates.
module pfc_back
  import pfc_pkg::*;
#(
  parameter int FRAME_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mem_wr_t     wr_i,
  input  job_t        job_i,
  input  logic        job_empty_i,
  output logic        job_pop_o,
  output logic        idle_o,
  input  logic        add_mode_i,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] sample_out_o,
  output logic        frame_last_o
);

  localparam int FW = $clog2(FRAME_LEN);

  typedef enum logic [1:0] {B_IDLE, B_WAITO, B_ISSUE, B_DRAIN} bstate_e;

  bstate_e            st_q;
  job_t               job_q;
  logic [FW-1:0]      n_q;
  logic [TAP_AW-1:0]  k_q;
  logic [31:0]        hist_mem [2**HIST_AW];
  logic [15:0]        coef_mem [TAP_DEPTH];
  logic [31:0]        hist_rd_q;
  logic [15:0]        coef_rd_q;
  logic [HIST_AW-1:0] h_ra;
  logic [LEN_W-1:0]   avail;
  logic               issue, tap_ok, k_last;
  logic               s1_v_q, s1_ok_q, s1_first_q, s1_last_q;
  logic               s2_v_q, s2_first_q, s2_last_q;
  logic signed [31:0] prod_q;
  logic signed [15:0] addend_q;
  logic signed [ACC_W-1:0] acc_q, acc_sum, rnd;
  logic               fin_v_q;
  logic signed [ACC_W-16:0] yr;
  logic signed [15:0] ysat;
  logic               out_v_q;
  logic [15:0]        out_q;
  logic               last_q;

  assign issue  = (st_q == B_ISSUE);
  assign k_last = (LEN_W'(k_q) == job_q.len - LEN_W'(1));
  assign avail  = job_q.vend - LEN_W'(FRAME_LEN - 1) + LEN_W'(n_q);
  assign tap_ok = (LEN_W'(k_q) < avail);
  assign h_ra   = job_q.start + HIST_AW'(n_q) - HIST_AW'(k_q);

  // sample history and partition taps
  always_ff @(posedge clk_i) begin
    if (wr_i.hist_we) hist_mem[wr_i.hist_addr] <= wr_i.hist_data;
    hist_rd_q <= hist_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.coef_we) coef_mem[wr_i.coef_addr] <= wr_i.coef_data;
    coef_rd_q <= coef_mem[k_q];
  end

  // accumulate and round half up, then add mode and saturation
  assign acc_sum = (s2_first_q ? '0 : acc_q) + ACC_W'(prod_q);
  assign rnd     = acc_q + ACC_W'(16384);
  always_comb begin
    yr = (ACC_W-15)'(rnd >>> 15);
    if (add_mode_i) yr = yr + (ACC_W-15)'(addend_q);
    if (yr > (ACC_W-15)'(32767))       ysat = 16'sh7FFF;
    else if (yr < -(ACC_W-15)'(32768)) ysat = -16'sh8000;
    else                               ysat = yr[15:0];
  end

  assign job_pop_o    = (st_q == B_IDLE) && !job_empty_i;
  assign idle_o       = (st_q == B_IDLE);
  assign empty        = !out_v_q;
  assign sample_out_o = out_q;
  assign frame_last_o = last_q;

  // MAC pipeline payload
  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    prod_q <= s1_ok_q ? $signed(coef_rd_q) * $signed(hist_rd_q[15:0]) : 32'sd0;
    if (s1_v_q && s1_first_q) addend_q <= $signed(hist_rd_q[31:16]);
    if (s2_v_q) acc_q <= acc_sum;
    if (fin_v_q) begin
      out_q  <= ysat;
      last_q <= (n_q == FW'(FRAME_LEN - 1));
    end
  end

  // sequencer over samples and taps, pipeline flags, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= B_IDLE;
      n_q        <= '0;
      k_q        <= '0;
      s1_v_q     <= 1'b0;
      s1_ok_q    <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      fin_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      s1_v_q     <= issue;
      s1_ok_q    <= issue && tap_ok;
      s1_first_q <= (k_q == '0);
      s1_last_q  <= k_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      fin_v_q    <= s2_v_q && s2_last_q;
      if (fin_v_q) out_v_q <= 1'b1;
      else if (pop && out_v_q) out_v_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            n_q  <= '0;
            k_q  <= '0;
            st_q <= B_WAITO;
          end
        end
        B_WAITO: if (!out_v_q) st_q <= B_ISSUE;
        B_ISSUE: begin
          if (k_last) begin
            k_q  <= '0;
            st_q <= B_DRAIN;
          end else begin
            k_q <= k_q + TAP_AW'(1);
          end
        end
        B_DRAIN: begin
          if (fin_v_q) begin
            if (n_q == FW'(FRAME_LEN - 1)) begin
              st_q <= B_IDLE;
            end else begin
              n_q  <= n_q + FW'(1);
              st_q <= B_WAITO;
            end
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/partitioned_fft_convolver.sv
// Top level of the partitioned long FIR convolver.
//
// Input queue: push/full. action selects an audio sample, a tap write or a
// transform of the stored taps into the active partition set. Results: the
// oldest output sample waits on sample_out_o while empty is low; pop takes it.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 filter_length,
// 1 add_mode) and cfg_data_i; cfg_ready_o is always high.
// Every FRAME_LEN-th sample closes a frame and yields FRAME_LEN results.
// The single MAC unit computes a frame's results one by one, each over len
// taps (len being the tap count at the last transform), and starts each
// result only once the one before has been popped. Samples are taken one a
// cycle while the two-entry job queue has room and no clear or transform is
// under way. A transform waits for the engine to drain, then copies len taps
// with full high. After reset the tap store is cleared, full high meanwhile.
// When pop is held low the engine holds its result; the queue fills and
// full rises, so nothing is lost.
module partitioned_fft_convolver
  import pfc_pkg::*;
#(
  parameter int FRAME_LEN      = 64,
  parameter int MAX_PARTITIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [15:0] sample_in_i,
  input  logic [15:0] addend_i,
  input  logic [11:0] tap_index_i,
  input  logic [15:0] tap_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] sample_out_o,
  output logic        frame_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [LEN_W-1:0] fl_q;
  logic             am_q;
  logic             job_push, job_full, job_pop, job_empty, back_idle;
  job_t             job_in, job_out;
  mem_wr_t          wr;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q <= LEN_W'(1);
      am_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_LENGTH: fl_q <= cfg_data_i;
        REG_ADD_MODE:      am_q <= cfg_data_i[0];
        default:           am_q <= am_q;
      endcase
    end
  end

  pfc_front #(.FRAME_LEN(FRAME_LEN), .MAX_PARTITIONS(MAX_PARTITIONS)) u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .sample_in_i, .addend_i,
    .tap_index_i, .tap_value_i,
    .filter_length_i(fl_q),
    .job_full_i(job_full), .job_empty_i(job_empty), .back_idle_i(back_idle),
    .job_push_o(job_push), .job_o(job_in), .wr_o(wr)
  );

  pfc_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(job_push), .job_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .job_o(job_out), .empty_o(job_empty)
  );

  pfc_back #(.FRAME_LEN(FRAME_LEN)) u_back (
    .clk_i, .rst_ni, .wr_i(wr), .job_i(job_out), .job_empty_i(job_empty),
    .job_pop_o(job_pop), .idle_o(back_idle), .add_mode_i(am_q),
    .pop, .empty, .sample_out_o, .frame_last_o
  );

  // a frame job never lands on a full queue
  a_job_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full) else $error("job pushed into full queue");

  // taps change only while the engine is at rest
  a_copy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.coef_we |-> (back_idle && job_empty)) else $error("tap copy while busy");

  // the engine takes jobs only when one is waiting
  a_job_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty) else $error("job pop from empty queue");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the partitioned FFT convolver top level.
`timescale 1ns / 1ps

module tb_top;
  import pfc_pkg::*;

  typedef struct {
    action_e     act;
    logic [15:0] smp;
    logic [15:0] add;
    logic [11:0] idx;
    logic [15:0] val;
  } req_t;

  typedef struct {
    logic [15:0] smp;
    bit          last;
  } out_t;

  localparam int FRAME = 64;
  localparam int SETTLE = 5000;  // longest transform copy plus margin

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, cfg_ready_o, frame_last_o;
  logic [15:0] sample_out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [12:0] cfg_data_i = '0;

  req_t cur_req = '{ACT_NONE, '0, '0, '0, '0};
  req_t pend_q[$];
  out_t conv_q[$];

  // predictor state
  shortint tap_mem[TAP_DEPTH];
  shortint part_taps[TAP_DEPTH];
  int      part_len;
  shortint frm_smp[FRAME];
  shortint frm_add[FRAME];
  int      frm_fill;
  shortint hist_q[$];
  bit      pred_add;
  int      pred_len;

  bit go = 0;
  bit in_taken = 0;
  int push_idle = 0;
  int pop_stall = 0;
  int hold_left = 0;
  int errs = 0;

  always #4 clk_i = ~clk_i;

  partitioned_fft_convolver u_top (
    .clk_i, .rst_ni, .push, .full,
    .action_i(cur_req.act), .sample_in_i(cur_req.smp), .addend_i(cur_req.add),
    .tap_index_i(cur_req.idx), .tap_value_i(cur_req.val),
    .empty, .pop, .sample_out_o, .frame_last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // emit one frame of convolved output
  function automatic void close_frame();
    longint acc;
    int y, pos;
    for (int n = 0; n < FRAME; n++) begin
      hist_q.push_back(frm_smp[n]);
      if (hist_q.size() > TAP_DEPTH + FRAME) void'(hist_q.pop_front());
    end
    for (int n = 0; n < FRAME; n++) begin
      pos = hist_q.size() - FRAME + n;
      acc = 0;
      for (int k = 0; k < part_len && k <= pos; k++)
        acc += longint'(part_taps[k]) * longint'(hist_q[pos - k]);
      y = int'((acc + 64'sd16384) >>> 15);
      if (pred_add) y += frm_add[n];
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      conv_q.push_back('{16'(y), n == FRAME - 1});
    end
  endfunction

  function automatic void predict(req_t r);
    int ln;
    case (r.act)
      ACT_TAP: tap_mem[r.idx] = shortint'(r.val);
      ACT_XFORM: begin
        ln = (pred_len == 0) ? 1 : pred_len;
        if (ln > TAP_DEPTH) ln = TAP_DEPTH;
        for (int k = 0; k < TAP_DEPTH; k++) part_taps[k] = (k < ln) ? tap_mem[k] : 16'sd0;
        part_len = ln;
        hist_q.delete();
      end
      ACT_SAMPLE: begin
        frm_smp[frm_fill] = shortint'(r.smp);
        frm_add[frm_fill] = shortint'(r.add);
        frm_fill++;
        if (frm_fill == FRAME) begin
          frm_fill = 0;
          close_frame();
        end
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (go && (!push || in_taken)) begin
      in_taken = 0;
      if (pend_q.size() > 0 && $urandom_range(0, 99) >= push_idle) begin
        cur_req = pend_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      in_taken = 1;
      predict(cur_req);
    end
  end

  // long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left--;
  end

  // result side stalls
  always @(negedge clk_i) begin
    pop <= go && hold_left == 0 && $urandom_range(0, 99) >= pop_stall;
  end

  // result checker
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && pop && !empty) begin
      if (conv_q.size() == 0) begin
        $error("unexpected result sample_out=%0h", sample_out_o);
        errs++;
      end else begin
        e = conv_q.pop_front();
        if (sample_out_o !== e.smp) begin
          $error("sample_out mismatch: expected %0d actual %0d",
                 $signed(e.smp), $signed(sample_out_o));
          errs++;
        end
        if (frame_last_o !== e.last) begin
          $error("frame_last mismatch: expected %0d actual %0d", e.last, frame_last_o);
          errs++;
        end
      end
    end
  end

  task automatic add_req(action_e a, logic [15:0] s, logic [15:0] d,
                         logic [11:0] i, logic [15:0] v);
    pend_q.push_back('{a, s, d, i, v});
  endtask

  task automatic cfg_write(logic idx, logic [12:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_FILTER_LENGTH) pred_len = data;
    else pred_add = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pend_q.size() != 0 || push || conv_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // taps, a transform, then frames of samples with stray taps, no-ops, transforms
  task automatic rand_phase(int ntaps, int nframes, int maxidx);
    int left;
    for (int t = 0; t < ntaps; t++)
      add_req(ACT_TAP, 16'($urandom()), 16'($urandom()),
              ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(0, maxidx)),
              rand_word());
    add_req(ACT_XFORM, 16'($urandom()), 16'($urandom()), 12'($urandom()), 16'($urandom()));
    left = nframes * FRAME;
    while (left > 0) begin
      case ($urandom_range(0, 99))
        0: add_req(ACT_XFORM, '0, '0, '0, '0);
        1, 2: add_req(ACT_NONE, 16'($urandom()), 16'($urandom()), 12'($urandom()),
                      16'($urandom()));
        3, 4, 5: add_req(ACT_TAP, '0, '0, 12'($urandom_range(0, maxidx)), rand_word());
        default: begin
          add_req(ACT_SAMPLE, rand_word(), rand_word(), 12'($urandom()), 16'($urandom()));
          left--;
        end
      endcase
    end
  endtask

  initial begin
    foreach (tap_mem[k]) begin
      tap_mem[k] = 0;
      part_taps[k] = 0;
    end
    part_len = 1;
    frm_fill = 0;
    pred_add = 0;
    pred_len = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    go = 1;

    // no idling: zero length, extreme taps, unused action, max negative product
    cfg_write(REG_FILTER_LENGTH, 13'd0);
    cfg_write(REG_ADD_MODE, 1'b0);
    add_req(ACT_TAP, '0, '0, 12'd0, 16'h8000);
    add_req(ACT_TAP, '0, '0, 12'hfff, 16'h7fff);
    add_req(ACT_NONE, 16'hffff, 16'hffff, 12'hfff, 16'hffff);
    add_req(ACT_XFORM, '0, '0, '0, '0);
    add_req(ACT_SAMPLE, 16'h8000, 16'h7fff, '0, '0);
    add_req(ACT_SAMPLE, 16'h7fff, 16'h8000, '0, '0);
    add_req(ACT_SAMPLE, 16'h0000, 16'h0000, '0, '0);
    add_req(ACT_SAMPLE, 16'h0001, 16'hffff, '0, '0);
    add_req(ACT_SAMPLE, 16'hffff, 16'h0001, '0, '0);
    for (int n = 5; n < FRAME; n++)
      add_req(ACT_SAMPLE, rand_word(), rand_word(), '0, '0);
    drain();

    // sender idling: add mode saturation at both ends, unit length
    push_idle = 52;
    cfg_write(REG_ADD_MODE, 1'b1);
    add_req(ACT_TAP, '0, '0, 12'd0, 16'h7fff);
    add_req(ACT_XFORM, '0, '0, '0, '0);
    for (int n = 0; n < FRAME; n++)
      if (n % 2) add_req(ACT_SAMPLE, 16'h7fff, 16'h7fff, '0, '0);
      else add_req(ACT_SAMPLE, 16'h8000, 16'h8000, '0, '0);
    drain();

    // receiver stalling, oversized length clamps to the full store
    push_idle = 0;
    pop_stall = 52;
    cfg_write(REG_ADD_MODE, 1'b0);
    cfg_write(REG_FILTER_LENGTH, 13'h1fff);
    rand_phase(10, 1, 4095);
    drain();

    // both idle; a long hold stalls the engine, so a transform waits and the
    // samples behind it back up the input
    push_idle = 6;
    pop_stall = 6;
    cfg_write(REG_ADD_MODE, 1'b1);
    cfg_write(REG_FILTER_LENGTH, 13'd130);
    hold_left = 20000;
    rand_phase(10, 1, 200);
    add_req(ACT_XFORM, '0, '0, '0, '0);
    for (int n = 0; n < 4; n++)
      add_req(ACT_SAMPLE, rand_word(), rand_word(), '0, '0);
    drain();

    if (errs == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: partitioned_fft_convolver.f
rtl/pfc_pkg.sv
rtl/pfc_job_fifo.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/partitioned_fft_convolver.sv
tb/tb_top.sv
